// ===== hw/rtl/mfm_sector_record_checker_assert.svh =====
// ----------------------------------------------------------------------------
// mfm sector record checker assertion macros
// shared concurrent assertion forms, clocked on clk with rst_n as disable
// ----------------------------------------------------------------------------
`ifndef MFM_SECTOR_RECORD_CHECKER_ASSERT_SVH
`define MFM_SECTOR_RECORD_CHECKER_ASSERT_SVH

// property holds at every edge outside reset
`define MSRC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define MSRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/msrc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msrc_pkg
// types, constants and the crc byte update for the mfm sector record checker
// ----------------------------------------------------------------------------
package msrc_pkg;

    localparam int SECTOR_BYTES = 512;
    localparam int INDEX_W      = 9;
    localparam int CNT_W        = ($clog2(SECTOR_BYTES + 2) > INDEX_W) ?
                                  $clog2(SECTOR_BYTES + 2) : INDEX_W;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_W    = 2;

    localparam logic [7:0]  SYNC_BYTE  = 8'hA1;
    localparam logic [7:0]  ID_MARK    = 8'hFE;
    localparam logic [7:0]  DATA_MARK  = 8'hFB;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [15:0] SYNC_PAIR  = 16'hA1A1;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CYLINDER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_HEAD     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SECTOR   = 2'd2;

    localparam logic [7:0] RST_MAX_CYLINDER = 8'd83;
    localparam logic [7:0] RST_MAX_HEAD     = 8'd1;
    localparam logic [7:0] RST_MAX_SECTOR   = 8'd20;

    // result kinds
    localparam logic [1:0] KIND_ID   = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       block_start;
        logic       track_start;
        logic [3:0] revolution;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         cylinder;
        logic [7:0]         head;
        logic [7:0]         sector;
        logic [7:0]         byte_value;
        logic [INDEX_W-1:0] byte_index;
        logic               crc_ok;
        logic               header_valid;
        logic               header_accepted;
        logic [3:0]         revolution_out;
    } result_t;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_MARK = 4'b0010,
        PH_ID   = 4'b0100,
        PH_DATA = 4'b1000
    } phase_t;

    // crc-16-ccitt, msb first, one byte
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    // crc after the a1 a1 preload and the leading a1 of the record
    localparam logic [15:0] CRC_PRELOAD    = crc_feed(crc_feed(CRC_INIT, SYNC_PAIR[15:8]),
                                                      SYNC_PAIR[7:0]);
    localparam logic [15:0] CRC_AFTER_SYNC = crc_feed(CRC_PRELOAD, SYNC_BYTE);

endpackage

// ===== hw/rtl/msrc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msrc_front
// takes record bytes, tracks the record phase, crc and sector header, and
// pushes one result request per reportable byte into the queue
// ----------------------------------------------------------------------------
`include "mfm_sector_record_checker_assert.svh"

module msrc_front
    import msrc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    input  logic                 q_full,
    output logic                 q_push,
    output result_t              q_push_data
);

    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] byte_count_reg, byte_count_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       id_bytes_reg [3];
    logic [7:0]       id_bytes_next [3];
    logic             cur_valid_reg, cur_valid_next;
    logic [7:0]       cur_cyl_reg, cur_cyl_next;
    logic [7:0]       cur_head_reg, cur_head_next;
    logic [7:0]       cur_sec_reg, cur_sec_next;
    logic [7:0]       max_cyl_reg, max_head_reg, max_sec_reg;

    logic        in_fire;
    logic [15:0] crc_new;
    logic [7:0]  zero_sec;
    logic        id_ok;
    logic        id_acc;
    result_t     res;
    logic        push;

    assign in_fire   = in_valid && !in_stall;
    assign in_stall  = q_full;
    assign cfg_ready = 1'b1;

    assign crc_new  = crc_feed(crc_reg, in_data.data_byte);
    assign zero_sec = id_bytes_reg[2] - 8'd1;
    assign id_ok    = (crc_new == 16'h0000);
    assign id_acc   = id_ok && (id_bytes_reg[2] != 8'd0) &&
                      (id_bytes_reg[0] <= max_cyl_reg) &&
                      (id_bytes_reg[1] <= max_head_reg) &&
                      (zero_sec <= max_sec_reg);

    always_comb
    begin
        phase_next      = phase_reg;
        byte_count_next = byte_count_reg;
        crc_next        = crc_reg;
        id_bytes_next   = id_bytes_reg;
        cur_valid_next  = cur_valid_reg;
        cur_cyl_next    = cur_cyl_reg;
        cur_head_next   = cur_head_reg;
        cur_sec_next    = cur_sec_reg;
        push            = 1'b0;
        res             = '0;
        res.revolution_out = in_data.revolution;

        // track start drops the header before the byte is handled
        if (in_data.track_start)
        begin
            cur_valid_next = 1'b0;
            cur_cyl_next   = 8'd0;
            cur_head_next  = 8'd0;
            cur_sec_next   = 8'd0;
        end

        if (in_data.block_start)
        begin
            if (in_data.data_byte == SYNC_BYTE)
            begin
                crc_next   = CRC_AFTER_SYNC;
                phase_next = PH_MARK;
            end
            else
            begin
                phase_next = PH_IDLE;
            end
            byte_count_next = '0;
        end
        else
        begin
            case (phase_reg)
                PH_MARK:
                begin
                    crc_next        = crc_new;
                    byte_count_next = '0;
                    if (in_data.data_byte == ID_MARK)
                    begin
                        phase_next = PH_ID;
                    end
                    else if (in_data.data_byte == DATA_MARK)
                    begin
                        phase_next = PH_DATA;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_ID:
                begin
                    crc_next = crc_new;
                    if (byte_count_reg < CNT_W'(3))
                    begin
                        id_bytes_next[byte_count_reg[1:0]] = in_data.data_byte;
                    end
                    if (byte_count_reg < CNT_W'(5))
                    begin
                        byte_count_next = byte_count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        if (id_acc)
                        begin
                            cur_valid_next = 1'b1;
                            cur_cyl_next   = id_bytes_reg[0];
                            cur_head_next  = id_bytes_reg[1];
                            cur_sec_next   = zero_sec;
                        end
                        phase_next          = PH_IDLE;
                        byte_count_next     = '0;
                        push                = 1'b1;
                        res.kind            = KIND_ID;
                        res.cylinder        = id_bytes_reg[0];
                        res.head            = id_bytes_reg[1];
                        res.sector          = zero_sec;
                        res.crc_ok          = id_ok;
                        res.header_valid    = cur_valid_next;
                        res.header_accepted = id_acc;
                    end
                end
                PH_DATA:
                begin
                    crc_next = crc_new;
                    if (byte_count_reg < CNT_W'(SECTOR_BYTES))
                    begin
                        push             = 1'b1;
                        res.kind         = KIND_DATA;
                        res.cylinder     = cur_cyl_next;
                        res.head         = cur_head_next;
                        res.sector       = cur_sec_next;
                        res.byte_value   = in_data.data_byte;
                        res.byte_index   = byte_count_reg[INDEX_W-1:0];
                        res.header_valid = cur_valid_next;
                        byte_count_next  = byte_count_reg + CNT_W'(1);
                    end
                    else if (byte_count_reg == CNT_W'(SECTOR_BYTES))
                    begin
                        byte_count_next = byte_count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        push             = 1'b1;
                        res.kind         = KIND_END;
                        res.cylinder     = cur_cyl_next;
                        res.head         = cur_head_next;
                        res.sector       = cur_sec_next;
                        res.crc_ok       = (crc_new == 16'h0000);
                        res.header_valid = cur_valid_next;
                        cur_valid_next   = 1'b0;
                        cur_cyl_next     = 8'd0;
                        cur_head_next    = 8'd0;
                        cur_sec_next     = 8'd0;
                        phase_next       = PH_IDLE;
                        byte_count_next  = '0;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    assign q_push      = in_fire && push;
    assign q_push_data = res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            byte_count_reg <= '0;
            crc_reg        <= CRC_INIT;
            id_bytes_reg   <= '{default: 8'd0};
            cur_valid_reg  <= 1'b0;
            cur_cyl_reg    <= 8'd0;
            cur_head_reg   <= 8'd0;
            cur_sec_reg    <= 8'd0;
        end
        else if (in_fire)
        begin
            phase_reg      <= phase_next;
            byte_count_reg <= byte_count_next;
            crc_reg        <= crc_next;
            id_bytes_reg   <= id_bytes_next;
            cur_valid_reg  <= cur_valid_next;
            cur_cyl_reg    <= cur_cyl_next;
            cur_head_reg   <= cur_head_next;
            cur_sec_reg    <= cur_sec_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_cyl_reg  <= RST_MAX_CYLINDER;
            max_head_reg <= RST_MAX_HEAD;
            max_sec_reg  <= RST_MAX_SECTOR;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MAX_CYLINDER: max_cyl_reg  <= cfg_data;
                REG_MAX_HEAD:     max_head_reg <= cfg_data;
                REG_MAX_SECTOR:   max_sec_reg  <= cfg_data;
                default:          max_sec_reg  <= max_sec_reg;
            endcase
        end
    end

    `MSRC_ASSERT(a_push_only_in_body, !q_push || (!in_data.block_start &&
                 (phase_reg == PH_ID || phase_reg == PH_DATA)),
                 "result request outside an id or data record")
    `MSRC_ASSERT_NEXT(a_end_clears_header, q_push && q_push_data.kind == KIND_END,
                      !cur_valid_reg && phase_reg == PH_IDLE,
                      "header still valid after data record end")
    `MSRC_ASSERT_NEXT(a_accept_sets_header, q_push && q_push_data.header_accepted,
                      cur_valid_reg && cur_sec_reg == $past(q_push_data.sector),
                      "accepted id not taken as current header")

endmodule

// ===== hw/rtl/msrc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msrc_queue
// short result request queue between the front and the output stage
// ----------------------------------------------------------------------------
`include "mfm_sector_record_checker_assert.svh"

module msrc_queue
    import msrc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    input  logic    pop,
    output result_t pop_data,
    output logic    empty
);

    result_t           entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `MSRC_ASSERT(a_no_overflow, !(push && full), "request pushed into a full queue")
    `MSRC_ASSERT(a_no_underflow, !(pop && empty), "request popped from an empty queue")
    `MSRC_ASSERT(a_count_bound, count_reg <= QCNT_W'(QUEUE_DEPTH), "queue count out of range")

endmodule

// ===== hw/rtl/msrc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msrc_back
// output stage: moves queued result requests into the output register
// ----------------------------------------------------------------------------
module msrc_back
    import msrc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_empty,
    input  result_t q_data,
    output logic    q_pop,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t out_data
);

    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg;
    logic    slot_free;

    // the slot frees when empty or when the held request is taken this edge
    assign slot_free      = !out_valid_reg || !out_stall;
    assign q_pop          = slot_free && !q_empty;
    assign out_valid_next = q_pop || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_data_reg <= q_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== hw/rtl/mfm_sector_record_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfm_sector_record_checker
// checks mfm id and data records (crc-16-ccitt, sector layout) and reports
// id results, data bytes with their index and data record end status
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  in       in_valid / in_stall    in_data (in_item_t), one decoded byte
//  out      out_valid / out_stall  out_data (result_t), zero or one per byte
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data (max cyl, head, sector)
//
// one byte accepted per cycle while in_stall is low; the crc update and header check finish in the
// accepting cycle, and a result reaches out through the request queue and then the output register
// a four entry request queue sits before the output register; in_stall rises
// only while it is full, so out_stall holds input back once five requests
// are pending, four queued and one in the output register
// reset idles the record phase, clears the header and loads the layout limits
// with 83, 1 and 20; cfg_ready is always high
module mfm_sector_record_checker
    import msrc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output result_t              out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    logic    q_push;
    result_t q_push_data;
    logic    q_full;
    logic    q_pop;
    result_t q_pop_data;
    logic    q_empty;

    msrc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_push_data (q_push_data)
    );

    msrc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    msrc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_pop_data),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
